>>> hdl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared widths, register codes and helpers for the touch coordinate
// calibration block.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int RAW_W   = 12;  // one converter reading
	localparam int SUM_W   = 18;  // group accumulators
	localparam int CNT_W   = 7;   // samples in the current group
	localparam int COEF_W  = 32;  // Q16.16 coefficients
	localparam int FRAC_W  = 16;  // fraction bits of a coefficient
	localparam int COORD_W = 16;  // screen coordinates
	localparam int PRD_W   = COEF_W + SUM_W + 1;  // signed coef times unsigned average
	localparam int ACC_W   = PRD_W + 1;           // two products and an offset
	localparam int ROT_W   = COORD_W + 2;         // room for size - coord - 1
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_COEF_AX   = 3'd0,
		REG_COEF_BX   = 3'd1,
		REG_COEF_CX   = 3'd2,
		REG_COEF_AY   = 3'd3,
		REG_COEF_BY   = 3'd4,
		REG_COEF_CY   = 3'd5,
		REG_ROTATION  = 3'd6,
		REG_SWAP_AXES = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	// load enables of the stages held inside the affine units
	typedef struct packed {
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} tcc_stage_en_t;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd65536;

	function automatic logic signed [COORD_W-1:0] sat_rot(input logic signed [ROT_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > ROT_W'(32767))
			r = 16'sh7fff;
		else if (v < -ROT_W'(32768))
			r = 16'sh8000;
		else
			r = COORD_W'(v);
		return r;
	endfunction

endpackage

>>> hdl/tcc_if.sv
// ----------------------------------------------------------------------------
// tcc_if
// Handshake channels of the touch coordinate calibration block.
// ----------------------------------------------------------------------------
interface tcc_sample_if import tcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;

	modport source (output valid, output raw_x, output raw_y, input ready);
	modport sink   (input valid, input raw_x, input raw_y, output ready);
endinterface

interface tcc_point_if import tcc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] screen_x;
	logic signed [COORD_W-1:0] screen_y;

	modport source (output valid, output screen_x, output screen_y, input ready);
	modport sink   (input valid, input screen_x, input screen_y, output ready);
endinterface

interface tcc_cfg_if import tcc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [COEF_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/tcc_affine.sv
// ----------------------------------------------------------------------------
// tcc_affine
// One axis of the affine calibration: a*X + b*Y + c in Q16.16, truncated
// toward zero to whole pixels and saturated to 16 bits, over three stages.
// ----------------------------------------------------------------------------
module tcc_affine import tcc_pkg::*; (
	input  logic                      clk,
	input  tcc_stage_en_t             ctl,
	input  logic signed [COEF_W-1:0]  coef_a,
	input  logic signed [COEF_W-1:0]  coef_b,
	input  logic signed [COEF_W-1:0]  coef_c,
	input  logic        [SUM_W-1:0]   px,
	input  logic        [SUM_W-1:0]   py,
	output logic signed [COORD_W-1:0] coord
);

	logic signed [PRD_W-1:0]   prod_a_s3, prod_b_s3;
	logic signed [COEF_W-1:0]  coef_c_s3;
	logic signed [ACC_W-1:0]   acc_s4;
	logic signed [ACC_W-1:0]   biased;
	logic signed [ACC_W-1:0]   whole;
	logic signed [COORD_W-1:0] coord_s5;

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			prod_a_s3 <= PRD_W'(coef_a) * $signed(PRD_W'(px));
			prod_b_s3 <= PRD_W'(coef_b) * $signed(PRD_W'(py));
			coef_c_s3 <= coef_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			acc_s4 <= ACC_W'(prod_a_s3) + ACC_W'(prod_b_s3) + ACC_W'(coef_c_s3);
		end
	end

	// bias negative sums so the shift truncates toward zero
	always_comb begin
		biased = acc_s4 + (acc_s4[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
		whole  = biased >>> FRAC_W;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			if (whole > ACC_W'(32767))
				coord_s5 <= 16'sh7fff;
			else if (whole < -ACC_W'(32768))
				coord_s5 <= 16'sh8000;
			else
				coord_s5 <= COORD_W'(whole);
		end
	end

	assign coord = coord_s5;

endmodule

>>> hdl/touch_coordinate_calibrate.sv
// ----------------------------------------------------------------------------
// touch_coordinate_calibrate
// Averages raw touch pairs, applies the affine calibration and maps the
// point to the display rotation.
// ----------------------------------------------------------------------------
// One raw pair is taken per cycle unless the input is stalled. Every
// SAMPLES_PER_POINT pairs close a group; its averaged point reaches the
// output register through a six-stage pipeline (average by reciprocal
// multiply, products, sum, truncate and saturate, rotation). Each stage
// holds while the one after it is full, so a waiting result stalls only
// the pairs that close a group; other pairs keep being accumulated. The one
// loop is the accumulator and sample counter, updated once per pair.
// Configuration is taken whenever offered and must only change while idle.
module touch_coordinate_calibrate import tcc_pkg::*; #(
	parameter int SAMPLES_PER_POINT = 8,
	parameter int SCREEN_WIDTH      = 320,
	parameter int SCREEN_HEIGHT     = 240,
	parameter int SAMPLE_BITS       = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	tcc_sample_if.sink  sample,
	tcc_point_if.source point,
	tcc_cfg_if.sink     cfg
);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_POINT - 1);
	localparam int               MASK_INT = (1 << SAMPLE_BITS) - 1;
	localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'(MASK_INT);
	// exact floor division of an SUM_W-bit sum by multiply and shift
	localparam int               DIV_L    = $clog2(SAMPLES_PER_POINT);
	localparam int               DIV_SH   = SUM_W + DIV_L;
	localparam int               RECIP_W  = SUM_W + 2;
	localparam int               DIVP_W   = SUM_W + RECIP_W;
	localparam longint           RECIP_INT =
		((longint'(1) << DIV_SH) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT;
	localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_INT);
	localparam logic signed [ROT_W-1:0] W_M1 = ROT_W'(SCREEN_WIDTH - 1);
	localparam logic signed [ROT_W-1:0] H_M1 = ROT_W'(SCREEN_HEIGHT - 1);

	// configuration
	logic signed [COEF_W-1:0] coef_ax_q, coef_bx_q, coef_cx_q;
	logic signed [COEF_W-1:0] coef_ay_q, coef_by_q, coef_cy_q;
	rot_t                     rotation_q;
	logic                     swap_q;

	// accumulation
	logic [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAW_W-1:0] rx, ry;
	logic [SUM_W-1:0] sum_x_nx, sum_y_nx;
	logic             last, in_fire;

	// pipeline
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic             free_s1, free_s2, free_s3, free_s4, free_s5, free_out;
	logic [SUM_W-1:0] sum_x_s1, sum_y_s1;
	logic [SUM_W-1:0] avg_x_s2, avg_y_s2;
	logic [DIVP_W-1:0] quot_x, quot_y;
	tcc_stage_en_t    stage_en;
	logic signed [COORD_W-1:0] cx_s5, cy_s5;
	logic signed [ROT_W-1:0]   w_minus_x, h_minus_y;
	logic signed [COORD_W-1:0] rot_x, rot_y;
	logic signed [COORD_W-1:0] out_x_q, out_y_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_ax_q  <= COEF_ONE;
			coef_bx_q  <= '0;
			coef_cx_q  <= '0;
			coef_ay_q  <= '0;
			coef_by_q  <= COEF_ONE;
			coef_cy_q  <= '0;
			rotation_q <= ROT_0;
			swap_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_COEF_AX:   coef_ax_q  <= cfg.data;
				REG_COEF_BX:   coef_bx_q  <= cfg.data;
				REG_COEF_CX:   coef_cx_q  <= cfg.data;
				REG_COEF_AY:   coef_ay_q  <= cfg.data;
				REG_COEF_BY:   coef_by_q  <= cfg.data;
				REG_COEF_CY:   coef_cy_q  <= cfg.data;
				REG_ROTATION:  rotation_q <= rot_t'(cfg.data[1:0]);
				REG_SWAP_AXES: swap_q     <= cfg.data[0];
			endcase
		end
	end

	// stage hand-off: a stage may load when empty or when it moves on
	assign free_out = !out_valid_q || point.ready;
	assign free_s5  = !v_s5 || free_out;
	assign free_s4  = !v_s4 || free_s5;
	assign free_s3  = !v_s3 || free_s4;
	assign free_s2  = !v_s2 || free_s3;
	assign free_s1  = !v_s1 || free_s2;

	// only the pair that closes a group needs room downstream
	assign last         = (cnt_q == CNT_LAST);
	assign sample.ready = !last || free_s1;
	assign in_fire      = sample.valid && sample.ready;

	always_comb begin
		rx       = (swap_q ? sample.raw_y : sample.raw_x) & RAW_MASK;
		ry       = (swap_q ? sample.raw_x : sample.raw_y) & RAW_MASK;
		sum_x_nx = sum_x_q + SUM_W'(rx);
		sum_y_nx = sum_y_q + SUM_W'(ry);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
		end else if (in_fire) begin
			if (last) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				cnt_q   <= '0;
			end else begin
				sum_x_q <= sum_x_nx;
				sum_y_q <= sum_y_nx;
				cnt_q   <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s1)  v_s1        <= in_fire && last;
			if (free_s2)  v_s2        <= v_s1;
			if (free_s3)  v_s3        <= v_s2;
			if (free_s4)  v_s4        <= v_s3;
			if (free_s5)  v_s5        <= v_s4;
			if (free_out) out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1) begin
			sum_x_s1 <= sum_x_nx;
			sum_y_s1 <= sum_y_nx;
		end
	end

	always_comb begin
		quot_x = DIVP_W'(sum_x_s1) * DIVP_W'(RECIP);
		quot_y = DIVP_W'(sum_y_s1) * DIVP_W'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (free_s2) begin
			avg_x_s2 <= SUM_W'(quot_x >> DIV_SH);
			avg_y_s2 <= SUM_W'(quot_y >> DIV_SH);
		end
	end

	assign stage_en = '{en_s3: free_s3, en_s4: free_s4, en_s5: free_s5};

	tcc_affine u_affine_x (
		.clk    (clk),
		.ctl    (stage_en),
		.coef_a (coef_ax_q),
		.coef_b (coef_bx_q),
		.coef_c (coef_cx_q),
		.px     (avg_x_s2),
		.py     (avg_y_s2),
		.coord  (cx_s5)
	);

	tcc_affine u_affine_y (
		.clk    (clk),
		.ctl    (stage_en),
		.coef_a (coef_ay_q),
		.coef_b (coef_by_q),
		.coef_c (coef_cy_q),
		.px     (avg_x_s2),
		.py     (avg_y_s2),
		.coord  (cy_s5)
	);

	always_comb begin
		w_minus_x = W_M1 - ROT_W'(cx_s5);
		h_minus_y = H_M1 - ROT_W'(cy_s5);
		unique case (rotation_q)
			ROT_0: begin
				rot_x = cx_s5;
				rot_y = cy_s5;
			end
			ROT_90: begin
				rot_x = cy_s5;
				rot_y = sat_rot(w_minus_x);
			end
			ROT_180: begin
				rot_x = sat_rot(w_minus_x);
				rot_y = sat_rot(h_minus_y);
			end
			ROT_270: begin
				rot_x = sat_rot(h_minus_y);
				rot_y = cx_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (free_out) begin
			out_x_q <= rot_x;
			out_y_q <= rot_y;
		end
	end

	assign point.valid    = out_valid_q;
	assign point.screen_x = out_x_q;
	assign point.screen_y = out_y_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("sample count beyond group size");

	a_group_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && last |=> v_s1 && cnt_q == '0 && sum_x_q == '0 && sum_y_q == '0)
		else $error("closing pair did not start a point");

	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> last && v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && out_valid_q)
		else $error("input stalled with room in the pipeline");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !point.ready |=> out_valid_q && $stable(out_x_q) && $stable(out_y_q))
		else $error("pending point changed before it was taken");
`endif

endmodule
